[rtl/bshc_pkg.sv]
// ----------------------------------------------------------------------------
// bshc_pkg
// Shared types, codes and charge-curve tables for the battery classifier.
// ----------------------------------------------------------------------------
package bshc_pkg;

    localparam int MV_W     = 15;
    localparam int CHARGE_W = 10;
    localparam int HEALTH_W = 2;
    localparam int SEG_W    = 4;
    localparam int REL_W    = 11;
    localparam int OFF_W    = 8;
    localparam int ADDR_W   = 2;

    // register indexes on the configuration port
    localparam logic [ADDR_W-1:0] REG_DISCONNECT = 2'd0;
    localparam logic [ADDR_W-1:0] REG_CRITICAL   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_WARNING    = 2'd2;

    // register reset values in mV
    localparam logic [MV_W-1:0] DISCONNECT_RST = 15'd5000;
    localparam logic [MV_W-1:0] CRITICAL_RST   = 15'd6800;
    localparam logic [MV_W-1:0] WARNING_RST    = 15'd7200;

    // health codes
    localparam logic [HEALTH_W-1:0] HEALTH_DISC = 2'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_OK   = 2'd1;
    localparam logic [HEALTH_W-1:0] HEALTH_WARN = 2'd2;
    localparam logic [HEALTH_W-1:0] HEALTH_CRIT = 2'd3;

    // charge curve limits
    localparam logic [MV_W-1:0]     CURVE_LOW_MV  = 15'd6600;
    localparam logic [MV_W-1:0]     CURVE_HIGH_MV = 15'd8400;
    localparam logic [REL_W-1:0]    CURVE_STEP_MV = 11'd200;
    localparam int                  CURVE_SEGS    = 9;
    localparam logic [CHARGE_W-1:0] CHARGE_EMPTY  = 10'd0;
    localparam logic [CHARGE_W-1:0] CHARGE_FULL   = 10'd1000;

    typedef struct packed {
        logic [MV_W-1:0] disconnect_mv;
        logic [MV_W-1:0] critical_mv;
        logic [MV_W-1:0] warning_mv;
    } t_cfg;

    typedef struct packed {
        logic [MV_W-1:0]     voltage_echo_mv;
        logic [HEALTH_W-1:0] health;
        logic [CHARGE_W-1:0] charge_tenths;
        logic                connected;
    } t_result;

    // charge at the low end of each segment, tenths of a percent
    function automatic logic [CHARGE_W-1:0] seg_charge(input logic [SEG_W-1:0] seg);
        logic [CHARGE_W-1:0] c;
        unique case (seg)
            4'd0:    c = 10'd0;
            4'd1:    c = 10'd100;
            4'd2:    c = 10'd250;
            4'd3:    c = 10'd400;
            4'd4:    c = 10'd500;
            4'd5:    c = 10'd600;
            4'd6:    c = 10'd700;
            4'd7:    c = 10'd800;
            4'd8:    c = 10'd900;
            default: c = 10'd0;
        endcase
        return c;
    endfunction

    // segment rise over 200 mV written as num/4 per mV (100 -> 2, 150 -> 3)
    function automatic logic [1:0] seg_slope(input logic [SEG_W-1:0] seg);
        logic [1:0] s;
        unique case (seg)
            4'd1, 4'd2: s = 2'd3;
            default:    s = 2'd2;
        endcase
        return s;
    endfunction

    // start of each segment relative to the curve low end, in mV
    function automatic logic [REL_W-1:0] seg_base(input logic [SEG_W-1:0] seg);
        logic [REL_W-1:0] b;
        unique case (seg)
            4'd0:    b = 11'd0;
            4'd1:    b = 11'd200;
            4'd2:    b = 11'd400;
            4'd3:    b = 11'd600;
            4'd4:    b = 11'd800;
            4'd5:    b = 11'd1000;
            4'd6:    b = 11'd1200;
            4'd7:    b = 11'd1400;
            4'd8:    b = 11'd1600;
            default: b = 11'd0;
        endcase
        return b;
    endfunction

endpackage

[rtl/bshc_cfg.sv]
// ----------------------------------------------------------------------------
// bshc_cfg
// Threshold registers written through the plain configuration port.
// ----------------------------------------------------------------------------
module bshc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bshc_pkg::ADDR_W-1:0] i_cfg_addr,
    input  logic [bshc_pkg::MV_W-1:0]   i_cfg_wdata,
    output bshc_pkg::t_cfg              o_cfg
);
    import bshc_pkg::*;

    t_cfg r_cfg;

    // register writes, unused index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.disconnect_mv <= DISCONNECT_RST;
            r_cfg.critical_mv   <= CRITICAL_RST;
            r_cfg.warning_mv    <= WARNING_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_DISCONNECT: r_cfg.disconnect_mv <= i_cfg_wdata;
                REG_CRITICAL:   r_cfg.critical_mv   <= i_cfg_wdata;
                REG_WARNING:    r_cfg.warning_mv    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/bshc_calc.sv]
// ----------------------------------------------------------------------------
// bshc_calc
// Combinational charge interpolation and health classification of one sample.
// ----------------------------------------------------------------------------
module bshc_calc (
    input  logic [bshc_pkg::MV_W-1:0] i_mv,
    input  bshc_pkg::t_cfg            i_cfg,
    output bshc_pkg::t_result         o_res
);
    import bshc_pkg::*;

    logic [MV_W-1:0]     rel_full;
    logic [REL_W-1:0]    rel;
    logic [SEG_W-1:0]    seg;
    logic [OFF_W-1:0]    off;
    logic [OFF_W+1:0]    scaled;
    logic [CHARGE_W-1:0] charge;
    logic                connected;

    // offset into the curve, only used strictly inside it
    assign rel_full = i_mv - CURVE_LOW_MV;
    assign rel      = rel_full[REL_W-1:0];

    // segment select by compares against the breakpoints
    always_comb begin
        seg = '0;
        for (int k = 1; k < CURVE_SEGS; k++) begin
            if (rel >= REL_W'(k) * CURVE_STEP_MV) begin
                seg = SEG_W'(k);
            end
        end
    end

    // interpolation, the slope is an exact quarter fraction so floor is a shift
    always_comb begin
        off    = OFF_W'(rel - seg_base(seg));
        scaled = (OFF_W+2)'(off) * (OFF_W+2)'(seg_slope(seg));
        priority if (i_mv <= CURVE_LOW_MV) begin
            charge = CHARGE_EMPTY;
        end else if (i_mv >= CURVE_HIGH_MV) begin
            charge = CHARGE_FULL;
        end else begin
            charge = seg_charge(seg) + CHARGE_W'(scaled >> 2);
        end
    end

    // connection and health class
    assign connected = (i_mv >= i_cfg.disconnect_mv);

    always_comb begin
        o_res.voltage_echo_mv = i_mv;
        o_res.connected       = connected;
        o_res.charge_tenths   = connected ? charge : CHARGE_EMPTY;
        priority if (!connected) begin
            o_res.health = HEALTH_DISC;
        end else if (i_mv <= i_cfg.critical_mv) begin
            o_res.health = HEALTH_CRIT;
        end else if (i_mv <= i_cfg.warning_mv) begin
            o_res.health = HEALTH_WARN;
        end else begin
            o_res.health = HEALTH_OK;
        end
    end

endmodule

[rtl/battery_soc_and_health_classifier.sv]
// ----------------------------------------------------------------------------
// battery_soc_and_health_classifier
// Pack voltage to state of charge and health class, one sample per cycle while m_axis is ready.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata[14:0] pack_mv
//  m_axis    | out       | tdata[0] connected, [10:1] charge_tenths,
//            |           |   [12:11] health, [27:13] voltage_echo_mv
//  cfg       | in        | index 0 disconnect_mv, 1 critical_mv, 2 warning_mv
//
//  One sample per cycle sustained while m_axis is ready; the input register
//  loads at the transfer and the result register loads from it, so a result
//  is offered on m_axis from the result register.
//  Synchronous active-low reset empties both stages and restores thresholds.
//  A stall on m_axis holds the result register; the input stage keeps
//  accepting until both stages are full.
// ----------------------------------------------------------------------------
module battery_soc_and_health_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [14:0] pack_mv, [15] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [0] connected, [10:1] charge_tenths,
                                          // [12:11] health, [27:13] voltage_echo_mv
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [14:0] i_cfg_wdata
);
    import bshc_pkg::*;

    t_cfg            cfg;
    t_result         res;
    logic            out_advance;
    logic            in_advance;
    logic            r_in_valid;
    logic [MV_W-1:0] r_in_mv;
    logic            r_out_valid;
    t_result         r_out;

    bshc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // stage flow control
    assign out_advance     = !r_out_valid || i_m_axis_tready;
    assign in_advance      = !r_in_valid || out_advance;
    assign o_s_axis_tready = in_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_advance) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance && i_s_axis_tvalid) begin
            r_in_mv <= i_s_axis_tdata[MV_W-1:0];
        end
    end

    bshc_calc u_calc (
        .i_mv  (r_in_mv),
        .i_cfg (cfg),
        .o_res (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_advance && r_in_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out};

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the battery charge and health classifier.
// A short table of hand-picked samples and threshold writes comes first,
// then six phases of random pack voltages under various threshold sets
// and handshake patterns. Each result transfer is compared field by field
// against typed table values or a behavioural predictor of charge and health.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bshc_pkg::*;

    localparam int CLK_HALF_NS    = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 175;
    localparam int HOLD_AT_ITEM   = 40;
    localparam int MV_MAX         = 32767;
    localparam int unsigned CURVE_STEP = 200;

    // index with no register behind it, writes must be ignored
    localparam logic [ADDR_W-1:0] REG_UNUSED = 2'd3;

    // charge at each curve point, 6600 mV upwards in 200 mV steps
    localparam int unsigned CURVE_TENTHS [0:9] =
        '{0, 100, 250, 400, 500, 600, 700, 800, 900, 1000};

    typedef enum logic {STEP_SAMPLE, STEP_WRITE} t_step_kind;

    typedef struct packed {
        t_step_kind          kind;
        logic [ADDR_W-1:0]   addr;
        logic [MV_W-1:0]     value;
        logic                typed;
        logic                connected;
        logic [CHARGE_W-1:0] charge_tenths;
        logic [HEALTH_W-1:0] health;
    } t_plan_row;

    // directed part: samples under reset thresholds, then odd threshold sets
    localparam int PLAN_ROWS = 35;
    localparam t_plan_row PLAN [0:PLAN_ROWS-1] = '{
        '{STEP_SAMPLE, REG_UNUSED,     15'd0,     1'b1, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd4999,  1'b1, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd5000,  1'b1, 1'b1, 10'd0,    HEALTH_CRIT},
        '{STEP_SAMPLE, REG_UNUSED,     15'd6600,  1'b1, 1'b1, 10'd0,    HEALTH_CRIT},
        '{STEP_SAMPLE, REG_UNUSED,     15'd6601,  1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd6800,  1'b1, 1'b1, 10'd100,  HEALTH_CRIT},
        '{STEP_SAMPLE, REG_UNUSED,     15'd6801,  1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd7000,  1'b1, 1'b1, 10'd250,  HEALTH_WARN},
        '{STEP_SAMPLE, REG_UNUSED,     15'd7100,  1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd7200,  1'b1, 1'b1, 10'd400,  HEALTH_WARN},
        '{STEP_SAMPLE, REG_UNUSED,     15'd7201,  1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd8000,  1'b1, 1'b1, 10'd800,  HEALTH_OK},
        '{STEP_SAMPLE, REG_UNUSED,     15'd8399,  1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd8400,  1'b1, 1'b1, 10'd1000, HEALTH_OK},
        '{STEP_SAMPLE, REG_UNUSED,     15'd32767, 1'b1, 1'b1, 10'd1000, HEALTH_OK},
        '{STEP_SAMPLE, REG_UNUSED,     15'd21845, 1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd10922, 1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        // nothing counts as disconnected any more
        '{STEP_WRITE,  REG_DISCONNECT, 15'd0,     1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd0,     1'b1, 1'b1, 10'd0,    HEALTH_CRIT},
        // critical only at zero, warning everywhere else
        '{STEP_WRITE,  REG_CRITICAL,   15'd0,     1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_WRITE,  REG_WARNING,    15'd32767, 1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd0,     1'b1, 1'b1, 10'd0,    HEALTH_CRIT},
        '{STEP_SAMPLE, REG_UNUSED,     15'd1,     1'b1, 1'b1, 10'd0,    HEALTH_WARN},
        // critical covers the whole range and wins over warning
        '{STEP_WRITE,  REG_WARNING,    15'd0,     1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_WRITE,  REG_CRITICAL,   15'd32767, 1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd32767, 1'b1, 1'b1, 10'd1000, HEALTH_CRIT},
        // thresholds out of their usual order
        '{STEP_WRITE,  REG_CRITICAL,   15'd7500,  1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_WRITE,  REG_WARNING,    15'd7000,  1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd7200,  1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd7600,  1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        // only full scale is connected
        '{STEP_WRITE,  REG_DISCONNECT, 15'd32767, 1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd32766, 1'b1, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd32767, 1'b1, 1'b1, 10'd1000, HEALTH_OK},
        // spare index, must leave the thresholds alone
        '{STEP_WRITE,  REG_UNUSED,     15'd0,     1'b0, 1'b0, 10'd0,    HEALTH_DISC},
        '{STEP_SAMPLE, REG_UNUSED,     15'd7000,  1'b0, 1'b0, 10'd0,    HEALTH_DISC}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [15:0]         i_s_axis_tdata;   // [14:0] pack_mv, [15] zero
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [31:0]         o_m_axis_tdata;   // [0] connected, [10:1] charge_tenths,
                                           // [12:11] health, [27:13] voltage_echo_mv
    logic                i_cfg_we;
    logic [ADDR_W-1:0]   i_cfg_addr;
    logic [MV_W-1:0]     i_cfg_wdata;

    // predictor copy of the thresholds
    t_cfg    thr;
    t_result soc_expected [$];

    int mismatches  = 0;
    int idle_cycles = 0;
    int burst_left  = 4;
    int tx_gap_max  = 2;
    int rx_mode     = 1;
    bit hold_request = 1'b0;

    battery_soc_and_health_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // connection, charge from the curve, then health class
    function automatic t_result soc_health_of(input logic [MV_W-1:0] mv);
        t_result     r;
        int unsigned rel, seg, off, lo, hi;
        r.voltage_echo_mv = mv;
        r.connected       = 1'b0;
        r.charge_tenths   = CHARGE_EMPTY;
        r.health          = HEALTH_DISC;
        if (mv >= thr.disconnect_mv) begin
            r.connected = 1'b1;
            if (mv <= CURVE_LOW_MV) begin
                r.charge_tenths = CHARGE_EMPTY;
            end else if (mv >= CURVE_HIGH_MV) begin
                r.charge_tenths = CHARGE_FULL;
            end else begin
                rel = int'(mv) - int'(CURVE_LOW_MV);
                seg = rel / CURVE_STEP;
                off = rel - seg * CURVE_STEP;
                lo  = CURVE_TENTHS[seg];
                hi  = CURVE_TENTHS[seg + 1];
                r.charge_tenths = CHARGE_W'(lo + (off * (hi - lo)) / CURVE_STEP);
            end
            if (mv <= thr.critical_mv) begin
                r.health = HEALTH_CRIT;
            end else if (mv <= thr.warning_mv) begin
                r.health = HEALTH_WARN;
            end else begin
                r.health = HEALTH_OK;
            end
        end
        return r;
    endfunction

    // random voltage, weighted towards the curve, thresholds and knees
    function automatic logic [MV_W-1:0] random_pack_mv();
        int v;
        int base;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = int'($urandom_range(6500, 8500));
            6: begin
                case ($urandom_range(0, 2))
                    0:       base = int'(thr.disconnect_mv);
                    1:       base = int'(thr.critical_mv);
                    default: base = int'(thr.warning_mv);
                endcase
                v = base + int'($urandom_range(0, 4)) - 2;
            end
            7:       v = 6600 + 200 * int'($urandom_range(0, 9)) + int'($urandom_range(0, 2)) - 1;
            default: v = int'($urandom_range(0, MV_MAX));
        endcase
        if (v < 0) begin
            v = 0;
        end else if (v > MV_MAX) begin
            v = MV_MAX;
        end
        return MV_W'(v);
    endfunction

    // offer one sample, record its expectation on transfer, then maybe pause
    task automatic send_sample(input logic [MV_W-1:0] mv, input logic typed,
                               input t_result typed_result);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, mv};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        soc_expected.push_back(typed ? typed_result : soc_health_of(mv));
        if (tx_gap_max > 0) begin
            burst_left--;
            if (burst_left <= 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, tx_gap_max)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (soc_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [MV_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (addr)
            REG_DISCONNECT: thr.disconnect_mv = value;
            REG_CRITICAL:   thr.critical_mv   = value;
            REG_WARNING:    thr.warning_mv    = value;
            default:        ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // receiver: always ready or ready in random stretches, with one long hold-off on request
    initial begin
        bit rx_on;
        int rx_left;
        rx_on   = 1'b1;
        rx_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (rx_mode == 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                if (rx_left <= 0) begin
                    rx_on   = !rx_on;
                    rx_left = rx_on ? $urandom_range(1, 8) : $urandom_range(1, 4);
                end
                rx_left--;
                i_m_axis_tready <= rx_on;
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[27:0]);
            if (soc_expected.size() == 0) begin
                $error("result transfer with nothing expected, tdata %h", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = soc_expected.pop_front();
                check_field("connected", 32'(want.connected), 32'(got.connected));
                check_field("charge_tenths", 32'(want.charge_tenths),
                            32'(got.charge_tenths));
                check_field("health", 32'(want.health), 32'(got.health));
                check_field("voltage_echo_mv", 32'(want.voltage_echo_mv),
                            32'(got.voltage_echo_mv));
                check_field("tdata padding", 32'd0, 32'(o_m_axis_tdata[31:28]));
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[battery_soc_and_health_classifier] ERROR");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_plan_row row;
        t_result   typed_result;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = REG_DISCONNECT;
        i_cfg_wdata     = '0;
        thr.disconnect_mv = DISCONNECT_RST;
        thr.critical_mv   = CRITICAL_RST;
        thr.warning_mv    = WARNING_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int k = 0; k < PLAN_ROWS; k++) begin
            row = PLAN[k];
            if (row.kind == STEP_WRITE) begin
                settle();
                write_reg(row.addr, row.value);
            end else begin
                typed_result.connected       = row.connected;
                typed_result.charge_tenths   = row.charge_tenths;
                typed_result.health          = row.health;
                typed_result.voltage_echo_mv = row.value;
                send_sample(row.value, row.typed, typed_result);
            end
        end

        // random phases, each setting its thresholds and handshake pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                1: begin
                    write_reg(REG_DISCONNECT, MV_W'($urandom_range(4000, 6800)));
                    write_reg(REG_CRITICAL, MV_W'($urandom_range(6400, 7600)));
                    write_reg(REG_WARNING, MV_W'($urandom_range(7600, 8600)));
                    tx_gap_max = 5;
                    rx_mode    = 1;
                end
                2: begin
                    write_reg(REG_DISCONNECT, '0);
                    write_reg(REG_CRITICAL, '0);
                    write_reg(REG_WARNING, '0);
                    tx_gap_max = 0;
                    rx_mode    = 1;
                end
                3: begin
                    write_reg(REG_DISCONNECT, '1);
                    write_reg(REG_CRITICAL, '1);
                    write_reg(REG_WARNING, '1);
                    tx_gap_max = 3;
                    rx_mode    = 0;
                end
                4: begin
                    write_reg(REG_DISCONNECT, MV_W'($urandom_range(0, MV_MAX)));
                    write_reg(REG_CRITICAL, MV_W'($urandom_range(0, MV_MAX)));
                    write_reg(REG_WARNING, MV_W'($urandom_range(0, MV_MAX)));
                    tx_gap_max = 8;
                    rx_mode    = 1;
                end
                default: begin
                    write_reg(REG_DISCONNECT, DISCONNECT_RST);
                    write_reg(REG_CRITICAL, CRITICAL_RST);
                    write_reg(REG_WARNING, WARNING_RST);
                    tx_gap_max = 0;
                    rx_mode    = 0;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // last phase: back-pressure long enough to fill both stages
                if (ph == PHASES - 1 && i == HOLD_AT_ITEM) begin
                    hold_request = 1'b1;
                end
                send_sample(random_pack_mv(), 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("[battery_soc_and_health_classifier] OK");
        end else begin
            $display("[battery_soc_and_health_classifier] ERROR");
        end
        $finish;
    end

endmodule
